>>> rtl/fpc_pkg.sv
package fpc_pkg;

    localparam int PAGE_COUNT  = 99;
    localparam int TABLE_DEPTH = 4 * PAGE_COUNT;
    localparam int ADDR_W      = 9;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd1200;
    localparam logic [6:0]  EDIT_MAX         = 7'd127;
    localparam logic [6:0]  EDIT_BIG_LIMIT   = 7'd117;
    localparam logic [6:0]  STEP_BIG         = 7'd10;
    localparam logic [6:0]  STEP_SMALL       = 7'd1;
    localparam logic [6:0]  PAGE_LAST        = 7'(PAGE_COUNT - 1);

    localparam logic [3:0]  CHORD_DOWN = 4'b0011;
    localparam logic [3:0]  CHORD_UP   = 4'b1100;

    typedef enum logic [1:0] {
        NOTICE_NONE   = 2'd0,
        NOTICE_CANCEL = 2'd1,
        NOTICE_SAVED  = 2'd2,
        NOTICE_SAME   = 2'd3
    } notice_t;

    typedef enum logic {
        REG_LONG_PRESS = 1'b0,
        REG_UNUSED     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]  levels;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic        send_program;
        logic [6:0]  program_res;
        logic [6:0]  page_now;
        logic        mode_now;
        logic [6:0]  edit_preset;
        logic [1:0]  notice;
        logic        store_write;
        logic [8:0]  store_address;
        logic [6:0]  store_value;
        logic        last;
    } out_word_t;

    // one pending result; fields marked _mem take the table read data
    typedef struct packed {
        logic              send;
        logic [6:0]        prog;
        logic              prog_mem;
        logic [6:0]        page;
        logic              mode;
        logic [6:0]        edit;
        logic              edit_mem;
        notice_t           notice;
        logic              commit;
        logic [ADDR_W-1:0] addr;
    } res_entry_t;

    typedef res_entry_t [MAX_RESULTS-1:0] res_list_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [6:0]        wr_data;
    } mem_req_t;

endpackage

>>> rtl/footswitch_preset_controller_top.sv
// Footswitch preset controller: one scan word (four button levels and a ms
// timestamp) in, zero to five result words out, the final one flagged last.
// A scan sits in the input register and then drops its results into the
// result buffer, which it holds until all are taken; so scans with at most
// one result flow at one per cycle while m_ready is high, and a busier scan
// delays the next by its results, sent one by one on the single result port.
// The preset table (396 entries) is one RAM read once per scan; after reset a
// clearing pass loads it and no scan is taken until it ends, while register
// writes are accepted throughout. long_press_ms lives at 0x0.
module footswitch_preset_controller_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpc_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fpc_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]               long_press_ms;
    logic                      table_busy;
    logic                      buf_free;
    logic [6:0]                rdata;
    logic                      adv;
    fpc_pkg::res_list_t        list;
    logic [fpc_pkg::CNT_W-1:0] n_res;
    fpc_pkg::mem_req_t         mem_req;

    fpc_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .long_press_ms (long_press_ms)
    );

    fpc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata   (rdata),
        .busy    (table_busy)
    );

    fpc_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .long_press_ms (long_press_ms),
        .table_busy    (table_busy),
        .buf_free      (buf_free),
        .rdata         (rdata),
        .adv           (adv),
        .list          (list),
        .n_res         (n_res),
        .mem_req       (mem_req)
    );

    fpc_resbuf u_resbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .list     (list),
        .n_res    (n_res),
        .rdata    (rdata),
        .buf_free (buf_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

>>> rtl/fpc_cfg.sv
module fpc_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] long_press_ms
);

    logic [15:0] long_press_reg;
    logic        sel_long;

    assign pready   = 1'b1;
    assign sel_long = (paddr[2] == fpc_pkg::REG_LONG_PRESS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg <= fpc_pkg::LONG_PRESS_RESET;
        end else if (psel && penable && pwrite && pready && sel_long) begin
            long_press_reg <= pwdata[15:0];
        end
    end

    assign prdata        = sel_long ? {16'd0, long_press_reg} : 32'd0;
    assign long_press_ms = long_press_reg;

endmodule

>>> rtl/fpc_table.sv
module fpc_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  fpc_pkg::mem_req_t req,
    output logic [6:0]        rdata,
    output logic              busy
);

    logic [6:0]                 mem [fpc_pkg::TABLE_DEPTH];
    logic [6:0]                 rdata_reg;
    logic                       clr_busy_reg;
    logic [fpc_pkg::ADDR_W-1:0] clr_addr_reg;

    // clearing pass: entry i gets i mod 128
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + fpc_pkg::ADDR_W'(1);
            if (clr_addr_reg == fpc_pkg::ADDR_W'(fpc_pkg::TABLE_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // read-first: a commit sees the old entry
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= clr_addr_reg[6:0];
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

>>> rtl/fpc_scan.sv
module fpc_scan (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fpc_pkg::in_word_t          s_data,
    input  logic [15:0]                long_press_ms,
    input  logic                       table_busy,
    input  logic                       buf_free,
    input  logic [6:0]                 rdata,
    output logic                       adv,
    output fpc_pkg::res_list_t         list,
    output logic [fpc_pkg::CNT_W-1:0]  n_res,
    output fpc_pkg::mem_req_t          mem_req
);

    logic                 in_valid_reg;
    fpc_pkg::in_word_t    in_reg;

    logic                 edit_mode_reg, edit_mode_next;
    logic [3:0]           prev_reg;
    logic [31:0]          stamp_reg  [4];
    logic [31:0]          stamp_next [4];
    logic [2:0]           chord_count_reg, chord_count_next;
    logic [3:0]           chord_mask_reg, chord_mask_next;
    logic                 long_done_reg, long_done_next;
    logic [6:0]           page_reg, page_next;
    logic [1:0]           slot_reg, slot_next;
    logic [6:0]           edit_value_reg, edit_value_next;
    logic                 ev_pend_reg, ev_pend_next;

    function automatic fpc_pkg::res_entry_t mk_entry(
        input logic                       send,
        input logic [6:0]                 prog,
        input logic                       prog_mem,
        input logic [6:0]                 page,
        input logic                       mode,
        input logic [6:0]                 edit,
        input logic                       edit_mem,
        input fpc_pkg::notice_t           notice,
        input logic                       commit,
        input logic [fpc_pkg::ADDR_W-1:0] addr
    );
        fpc_pkg::res_entry_t e;
        e.send     = send;
        e.prog     = prog;
        e.prog_mem = prog_mem;
        e.page     = page;
        e.mode     = mode;
        e.edit     = edit;
        e.edit_mem = edit_mem;
        e.notice   = notice;
        e.commit   = commit;
        e.addr     = addr;
        return e;
    endfunction

    assign adv     = in_valid_reg && buf_free;
    assign s_ready = !table_busy && (!in_valid_reg || adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    always_comb begin
        logic [3:0]              lv;
        logic [31:0]             now;
        logic [2:0]              cnt;
        logic                    md;
        logic                    ld;
        logic [6:0]              ev;
        logic [1:0]              es;
        logic [6:0]              pg;
        logic [2:0]              cc;
        logic [3:0]              cm;
        logic                    bl;
        logic                    pl;
        logic [1:0]              bi;
        logic                    down;
        logic                    up;
        logic [fpc_pkg::CNT_W-1:0] n;
        logic                    ld_mem;
        logic                    wr;
        logic [fpc_pkg::ADDR_W-1:0] addr;

        lv     = in_reg.levels;
        now    = in_reg.now_ms;
        cnt    = 3'(lv[0]) + 3'(lv[1]) + 3'(lv[2]) + 3'(lv[3]);
        md     = edit_mode_reg;
        ld     = long_done_reg;
        ev     = ev_pend_reg ? rdata : edit_value_reg;
        es     = slot_reg;
        pg     = page_reg;
        cc     = chord_count_reg;
        cm     = chord_mask_reg;
        bl     = 1'b0;
        pl     = 1'b0;
        bi     = 2'd0;
        down   = 1'b0;
        up     = 1'b0;
        n      = '0;
        ld_mem = 1'b0;
        wr     = 1'b0;
        addr   = {page_reg, 2'b00};
        list   = '0;
        for (int k = 0; k < 4; k++) begin
            stamp_next[k] = stamp_reg[k];
        end

        for (int i = 0; i < 4; i++) begin
            bl = lv[i];
            pl = prev_reg[i];
            bi = 2'(i);
            if (bl && !pl && cnt == 3'd1) begin
                if (!md) begin
                    addr    = {pg, bi};
                    list[n] = mk_entry(1'b1, 7'd0, 1'b1, pg, md, ev, 1'b0,
                                       fpc_pkg::NOTICE_NONE, 1'b0, '0);
                    n       = n + fpc_pkg::CNT_W'(1);
                end
                stamp_next[i] = now;
                ld            = 1'b0;
            end
            if (!ld && bl && pl && cnt == 3'd1) begin
                if ((now - stamp_reg[i]) > {16'd0, long_press_ms}) begin
                    if (!md) begin
                        md      = 1'b1;
                        es      = bi;
                        ld_mem  = 1'b1;
                        addr    = {pg, bi};
                        list[n] = mk_entry(1'b0, 7'd0, 1'b0, pg, md, ev, 1'b1,
                                           fpc_pkg::NOTICE_NONE, 1'b0, '0);
                        n       = n + fpc_pkg::CNT_W'(1);
                    end
                    ld = 1'b1;
                end
            end
            if (!bl && pl && !ld && md) begin
                case (bi)
                    2'd0: if (ev >= fpc_pkg::STEP_BIG) ev = ev - fpc_pkg::STEP_BIG;
                    2'd1: if (ev >= fpc_pkg::STEP_SMALL) ev = ev - fpc_pkg::STEP_SMALL;
                    2'd2: if (ev < fpc_pkg::EDIT_MAX) ev = ev + fpc_pkg::STEP_SMALL;
                    default: if (ev < fpc_pkg::EDIT_BIG_LIMIT) ev = ev + fpc_pkg::STEP_BIG;
                endcase
                list[n] = mk_entry(1'b1, ev, 1'b0, pg, md, ev, 1'b0,
                                   fpc_pkg::NOTICE_NONE, 1'b0, '0);
                n       = n + fpc_pkg::CNT_W'(1);
            end
        end

        if (cnt > cc) begin
            cm = lv;
            cc = cnt;
        end

        if (cc > 3'd1 && cnt == 3'd0) begin
            down = (cm == fpc_pkg::CHORD_DOWN);
            up   = (cm == fpc_pkg::CHORD_UP);
            if (!md) begin
                if (down && pg > 7'd0) begin
                    pg = pg - 7'd1;
                end else if (up && pg < fpc_pkg::PAGE_LAST) begin
                    pg = pg + 7'd1;
                end
                addr    = {pg, 2'b00};
                list[n] = mk_entry(1'b1, 7'd0, 1'b1, pg, md, ev, 1'b0,
                                   fpc_pkg::NOTICE_NONE, 1'b0, '0);
                n       = n + fpc_pkg::CNT_W'(1);
            end else if (down) begin
                addr    = {pg, es};
                md      = 1'b0;
                list[n] = mk_entry(1'b1, 7'd0, 1'b1, pg, md, ev, 1'b0,
                                   fpc_pkg::NOTICE_CANCEL, 1'b0, '0);
                n       = n + fpc_pkg::CNT_W'(1);
            end else if (up) begin
                addr    = {pg, es};
                wr      = 1'b1;
                md      = 1'b0;
                list[n] = mk_entry(1'b1, ev, 1'b0, pg, md, ev, 1'b0,
                                   fpc_pkg::NOTICE_NONE, 1'b1, addr);
                n       = n + fpc_pkg::CNT_W'(1);
            end
            cm = 4'd0;
            cc = 3'd0;
        end

        edit_mode_next   = md;
        long_done_next   = ld;
        edit_value_next  = ev;
        ev_pend_next     = ld_mem;
        slot_next        = es;
        page_next        = pg;
        chord_count_next = cc;
        chord_mask_next  = cm;
        n_res            = n;
        mem_req.rd_en    = adv;
        mem_req.wr_en    = adv && wr;
        mem_req.addr     = addr;
        mem_req.wr_data  = ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edit_mode_reg   <= 1'b0;
            prev_reg        <= 4'd0;
            chord_count_reg <= 3'd0;
            chord_mask_reg  <= 4'd0;
            long_done_reg   <= 1'b0;
            page_reg        <= 7'd0;
            slot_reg        <= 2'd0;
            edit_value_reg  <= 7'd0;
            ev_pend_reg     <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                stamp_reg[k] <= 32'd0;
            end
        end else if (adv) begin
            edit_mode_reg   <= edit_mode_next;
            prev_reg        <= in_reg.levels;
            chord_count_reg <= chord_count_next;
            chord_mask_reg  <= chord_mask_next;
            long_done_reg   <= long_done_next;
            page_reg        <= page_next;
            slot_reg        <= slot_next;
            edit_value_reg  <= edit_value_next;
            ev_pend_reg     <= ev_pend_next;
            for (int k = 0; k < 4; k++) begin
                stamp_reg[k] <= stamp_next[k];
            end
        end
    end

endmodule

>>> rtl/fpc_resbuf.sv
module fpc_resbuf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  fpc_pkg::res_list_t        list,
    input  logic [fpc_pkg::CNT_W-1:0] n_res,
    input  logic [6:0]                rdata,
    output logic                      buf_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output fpc_pkg::out_word_t        m_data
);

    logic [fpc_pkg::CNT_W-1:0] cnt_reg;
    fpc_pkg::res_list_t        list_reg, list_shift;
    fpc_pkg::res_entry_t       head;
    logic                      changed;
    logic                      take;

    assign m_valid  = (cnt_reg != '0);
    assign take     = m_valid && m_ready;
    assign buf_free = !m_valid || (m_ready && cnt_reg == fpc_pkg::CNT_W'(1));

    always_comb begin
        list_shift = '0;
        for (int k = 0; k < fpc_pkg::MAX_RESULTS - 1; k++) begin
            list_shift[k] = list_reg[k + 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (adv) begin
            cnt_reg <= n_res;
        end else if (take) begin
            cnt_reg <= cnt_reg - fpc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            list_reg <= list;
        end else if (take) begin
            list_reg <= list_shift;
        end
    end

    assign head    = list_reg[0];
    assign changed = (rdata != head.edit);

    always_comb begin
        m_data.send_program  = head.send;
        m_data.program_res   = head.prog_mem ? rdata : head.prog;
        m_data.page_now      = head.page;
        m_data.mode_now      = head.mode;
        m_data.edit_preset   = head.edit_mem ? rdata : head.edit;
        m_data.notice        = head.notice;
        m_data.store_write   = 1'b0;
        m_data.store_address = '0;
        m_data.store_value   = '0;
        if (head.commit) begin
            m_data.notice = changed ? fpc_pkg::NOTICE_SAVED : fpc_pkg::NOTICE_SAME;
            if (changed) begin
                m_data.store_write   = 1'b1;
                m_data.store_address = head.addr;
                m_data.store_value   = head.edit;
            end
        end
        m_data.last = (cnt_reg == fpc_pkg::CNT_W'(1));
    end

endmodule
